// File: hdl/srwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srwt_pkg
// shared types, constants and tables for the sound register write translator
// ----------------------------------------------------------------------------
package srwt_pkg;

  localparam int COUNTER_BITS = 24;
  localparam int OFFSET_BITS  = 24;
  localparam int IN_DATA_BITS = 24;
  localparam int OUT_DATA_BITS = 48;
  localparam int KIND_BITS    = 2;

  localparam logic [7:0] HIGH_PAGE      = 8'hFF;
  localparam logic [7:0] MARKER_REG     = 8'h1F;
  localparam logic [3:0] WAVE_WINDOW    = 4'h3;
  localparam logic [3:0] WAVE_BASE_HI   = 4'h9;
  localparam logic [7:0] WAVE_CTRL_REG  = 8'h70;
  localparam logic [7:0] WAVE_CTRL_DATA = 8'h40;
  localparam logic [7:0] MASK_REG_A     = 8'h70;
  localparam logic [7:0] MASK_DATA_A    = 8'h80;
  localparam logic [7:0] MASK_REG_B     = 8'h73;
  localparam logic [7:0] MASK_DATA_B    = 8'h60;
  localparam logic [7:0] LEAD_RESET     = 8'hB3;
  localparam logic [COUNTER_BITS-1:0] STEP_BYTES = COUNTER_BITS'(3);
  localparam logic [2:0] END_CH0_SLOT   = 3'd4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CMD  = 2'd0,
    KIND_LOOP = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // one result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] target_register;
    logic [7:0] target_data;
    logic [2:0] loop_slot;
    logic       recording_ended;
    logic       last_of_item;
  } result_t;

  // decode of the item in the input register
  typedef struct packed {
    logic    emit;       // a beat is produced at this phase
    logic    advance;    // beat is a command, counter moves on
    logic    stop;       // recording ends with this beat
    logic    two_beats;  // wave ram write, second beat follows
    result_t beat;
  } dec_t;

  // low bytes 0x10-0x26 to target register, zero means unmapped
  function automatic logic [7:0] reg_map(input logic [7:0] low);
    logic [7:0] t;
    unique case (low)
      8'h10: t = 8'h60;
      8'h11: t = 8'h62;
      8'h12: t = 8'h63;
      8'h13: t = 8'h64;
      8'h14: t = 8'h65;
      8'h16: t = 8'h68;
      8'h17: t = 8'h69;
      8'h18: t = 8'h6C;
      8'h19: t = 8'h6D;
      8'h1A: t = 8'h70;
      8'h1B: t = 8'h72;
      8'h1C: t = 8'h73;
      8'h1D: t = 8'h74;
      8'h1E: t = 8'h75;
      8'h20: t = 8'h78;
      8'h21: t = 8'h79;
      8'h22: t = 8'h7C;
      8'h23: t = 8'h7D;
      8'h24: t = 8'h80;
      8'h25: t = 8'h81;
      8'h26: t = 8'h84;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  // loop marker byte to slot, bit 3 flags a bad marker
  function automatic logic [3:0] marker_slot(input logic [7:0] data);
    logic [3:0] s;
    unique case (data)
      8'h01: s = 4'd0;
      8'h02: s = 4'd1;
      8'h04: s = 4'd2;
      8'h08: s = 4'd3;
      8'h81: s = 4'd4;
      8'h82: s = 4'd5;
      8'h84: s = 4'd6;
      8'h88: s = 4'd7;
      default: s = 4'b1000;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/srwt_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srwt_decode
// translates one bus write into the beat of the current phase
// ----------------------------------------------------------------------------
module srwt_decode (
  input  wire logic [15:0]     write_address,
  input  wire logic [7:0]      write_data,
  input  wire logic            phase,
  input  wire logic            recording,
  output srwt_pkg::dec_t       dec
);
  import srwt_pkg::*;

  logic [7:0] low;
  logic [7:0] mapped;
  logic [3:0] slot;

  assign low    = write_address[7:0];
  assign mapped = reg_map(low);
  assign slot   = marker_slot(write_data);

  always_comb begin
    dec = '0;
    dec.beat.kind = KIND_CMD;
    if (recording && (write_address[15:8] == HIGH_PAGE)) begin
      if (low == MARKER_REG) begin
        dec.emit = 1'b1;
        dec.beat.target_data  = write_data;
        dec.beat.last_of_item = 1'b1;
        if (slot[3]) begin
          dec.beat.kind = KIND_BAD;
          dec.beat.recording_ended = 1'b1;
          dec.stop = 1'b1;
        end else begin
          dec.beat.kind      = KIND_LOOP;
          dec.beat.loop_slot = slot[2:0];
          dec.stop = (slot[2:0] == END_CH0_SLOT);
          dec.beat.recording_ended = (slot[2:0] == END_CH0_SLOT);
        end
      end else if (low[7:4] == WAVE_WINDOW) begin
        dec.emit      = 1'b1;
        dec.advance   = 1'b1;
        dec.two_beats = 1'b1;
        if (phase) begin
          dec.beat.target_register = WAVE_CTRL_REG;
          dec.beat.target_data     = WAVE_CTRL_DATA;
          dec.beat.last_of_item    = 1'b1;
        end else begin
          dec.beat.target_register = {WAVE_BASE_HI, low[3:0]};
          dec.beat.target_data     = write_data;
        end
      end else if (mapped != 8'h00) begin
        dec.emit    = 1'b1;
        dec.advance = 1'b1;
        dec.beat.target_register = mapped;
        dec.beat.last_of_item    = 1'b1;
        priority if (mapped == MASK_REG_A) begin
          dec.beat.target_data = write_data & MASK_DATA_A;
        end else if (mapped == MASK_REG_B) begin
          dec.beat.target_data = write_data & MASK_DATA_B;
        end else begin
          dec.beat.target_data = write_data;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/sound_register_write_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sound_register_write_translator
// records sound register writes from the cpu bus as register commands
// ----------------------------------------------------------------------------
// Bus writes arrive as beats on the s_ side and land in an input register.
// From there one pass of decode logic fills the output register, so an item
// producing a single beat (register command, loop point, bad marker) or none
// at all leaves the input register once its beat is loaded, and the block
// takes one item per cycle while the output register is not stalled. A wave
// ram write produces two beats through the single output register and holds
// the input register until its second beat is loaded. An input beat passes
// the input register and then the output register. The byte counter advances
// by 3 per command beat. Loop points are reported through the stream_offset
// of the loop beat. command_lead_byte is held for the downstream stream
// writer and appears in no beat.
// ----------------------------------------------------------------------------
module sound_register_write_translator (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: command_lead_byte
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,
  // input beats
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // write_address[15:0], write_data[23:16]
  // result beats
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // target_register[7:0], target_data[15:8],
                                      // stream_offset[39:16], loop_slot[42:40],
                                      // recording_ended[43], zero fill [47:44]
  output logic [1:0]       m_tuser,   // result_kind[1:0]
  output logic             m_tlast    // last_of_item
);
  import srwt_pkg::*;

  // input register
  logic        in_valid;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic        phase;     // second beat of a wave write is due

  // block state
  logic                    recording;
  logic [COUNTER_BITS-1:0] counter;
  logic [7:0]              command_lead_byte;

  // output register
  result_t                 out_beat;
  logic [OFFSET_BITS-1:0]  out_offset;

  dec_t dec;
  logic out_free;
  logic load;
  logic in_done;

  srwt_decode u_decode (
    .write_address (in_addr),
    .write_data    (in_data),
    .phase         (phase),
    .recording     (recording),
    .dec           (dec)
  );

  // output register can take a beat when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  assign load     = in_valid && dec.emit && out_free;
  // item leaves once its final beat is loaded, or at once if it has none
  assign in_done  = in_valid && (!dec.emit || (load && (!dec.two_beats || phase)));
  assign s_tready = !in_valid || in_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      phase             <= 1'b0;
      m_tvalid          <= 1'b0;
      recording         <= 1'b1;
      counter           <= '0;
      command_lead_byte <= LEAD_RESET;
    end else begin
      if (cfg_wen) begin
        command_lead_byte <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (in_done) begin
        in_valid <= 1'b0;
      end
      if (in_done) begin
        phase <= 1'b0;
      end else if (load) begin
        phase <= 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
        if (dec.advance) begin
          counter <= counter + STEP_BYTES;
        end
        if (dec.stop) begin
          recording <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_addr <= s_tdata[15:0];
      in_data <= s_tdata[23:16];
    end
    if (load) begin
      out_beat   <= dec.beat;
      out_offset <= OFFSET_BITS'(counter);
    end
  end

  assign m_tdata = {4'b0000, out_beat.recording_ended, out_beat.loop_slot, out_offset,
                    out_beat.target_data, out_beat.target_register};
  assign m_tuser = out_beat.kind;
  assign m_tlast = out_beat.last_of_item;

endmodule
`default_nettype wire

// File: hdl/srwt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srwt_checker
// port level checks of the sound register write translator
// ----------------------------------------------------------------------------
module srwt_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast
);
  import srwt_pkg::*;

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // nothing follows the beat that ends recording
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[43] |=> !m_tvalid)
    else $error("beat after recording ended");

  // marker beats are single and carry no register
  a_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_CMD) |-> m_tlast && (m_tdata[7:0] == 8'h00))
    else $error("marker beat malformed");

  // a bad marker always ends recording with slot zero
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_BAD) |-> m_tdata[43] && (m_tdata[42:40] == 3'd0))
    else $error("bad marker beat malformed");

endmodule

bind sound_register_write_translator srwt_checker u_srwt_checker (.*);
`default_nettype wire

// File: verif/sound_register_write_translator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_register_write_translator_tb
// Drives bus writes into the translator under random sender and receiver
// pacing. A predictor keeps its own recording flag, byte counter and loop
// slots, queues the register, loop and marker beats each write should cause,
// and checks every output beat against the oldest one waiting.
// ----------------------------------------------------------------------------
import srwt_pkg::*;

// one expected or observed result beat
typedef struct packed {
  kind_t                  kind;
  logic [7:0]             target_reg;
  logic [7:0]             target_dat;
  logic [OFFSET_BITS-1:0] offset;
  logic [2:0]             slot;
  logic                   ended;
  logic                   last_beat;
} beat_t;

// loop marker byte to loop slot, -1 for a marker byte with no slot
function automatic int loop_slot_for(input logic [7:0] v);
  case (v)
    8'h01: return 0;
    8'h02: return 1;
    8'h04: return 2;
    8'h08: return 3;
    8'h81: return 4;
    8'h82: return 5;
    8'h84: return 6;
    8'h88: return 7;
    default: return -1;
  endcase
endfunction

class srwt_scoreboard;
  bit                      recording;
  logic [COUNTER_BITS-1:0] byte_count;
  logic [COUNTER_BITS-1:0] loop_marks [8];
  logic [7:0]              lead_byte;
  beat_t                   recorded_beats [$];
  int                      mismatches;
  int                      n_commands;
  int                      n_wave;
  int                      n_loops;
  int                      n_bad;

  function new();
    recording  = 1'b1;
    byte_count = '0;
    lead_byte  = LEAD_RESET;
    foreach (loop_marks[i]) loop_marks[i] = '0;
    mismatches = 0;
    n_commands = 0;
    n_wave     = 0;
    n_loops    = 0;
    n_bad      = 0;
  endfunction

  // sound register low byte to its target register, zero when unmapped
  function logic [7:0] sound_target(input logic [7:0] low);
    case (low)
      8'h10: return 8'h60;
      8'h11: return 8'h62;
      8'h12: return 8'h63;
      8'h13: return 8'h64;
      8'h14: return 8'h65;
      8'h16: return 8'h68;
      8'h17: return 8'h69;
      8'h18: return 8'h6C;
      8'h19: return 8'h6D;
      8'h1A: return 8'h70;
      8'h1B: return 8'h72;
      8'h1C: return 8'h73;
      8'h1D: return 8'h74;
      8'h1E: return 8'h75;
      8'h20: return 8'h78;
      8'h21: return 8'h79;
      8'h22: return 8'h7C;
      8'h23: return 8'h7D;
      8'h24: return 8'h80;
      8'h25: return 8'h81;
      8'h26: return 8'h84;
      default: return 8'h00;
    endcase
  endfunction

  function void push_beat(input kind_t k, input logic [7:0] tr, input logic [7:0] td,
                          input logic [2:0] sl, input logic en, input logic lb);
    beat_t b;
    b.kind       = k;
    b.target_reg = tr;
    b.target_dat = td;
    b.offset     = byte_count[OFFSET_BITS-1:0];
    b.slot       = sl;
    b.ended      = en;
    b.last_beat  = lb;
    recorded_beats.push_back(b);
    if (k == KIND_CMD) n_commands++;
  endfunction

  // predict the beats caused by one accepted bus write
  function void record_write(input logic [15:0] addr, input logic [7:0] data);
    logic [7:0] low;
    logic [7:0] tgt;
    logic [7:0] dat;
    int         slot;
    low = addr[7:0];
    dat = data;
    if (!recording || addr[15:8] != HIGH_PAGE) return;
    if (low == MARKER_REG) begin
      slot = loop_slot_for(data);
      if (slot < 0) begin
        recording = 1'b0;
        push_beat(KIND_BAD, 8'h00, data, 3'd0, 1'b1, 1'b1);
        n_bad++;
      end else begin
        loop_marks[slot] = byte_count;
        if (slot == END_CH0_SLOT) recording = 1'b0;
        push_beat(KIND_LOOP, 8'h00, data, 3'(slot), slot == END_CH0_SLOT, 1'b1);
        n_loops++;
      end
      return;
    end
    if (low[7:4] == WAVE_WINDOW) begin
      push_beat(KIND_CMD, {WAVE_BASE_HI, low[3:0]}, dat, 3'd0, 1'b0, 1'b0);
      byte_count += STEP_BYTES;
      push_beat(KIND_CMD, WAVE_CTRL_REG, WAVE_CTRL_DATA, 3'd0, 1'b0, 1'b1);
      byte_count += STEP_BYTES;
      n_wave++;
      return;
    end
    tgt = sound_target(low);
    if (tgt == 8'h00) return;
    if (tgt == MASK_REG_A) dat &= MASK_DATA_A;
    else if (tgt == MASK_REG_B) dat &= MASK_DATA_B;
    push_beat(KIND_CMD, tgt, dat, 3'd0, 1'b0, 1'b1);
    byte_count += STEP_BYTES;
  endfunction

  function string beat_text(input beat_t b);
    return $sformatf("kind %0d reg %02h data %02h offset %06h slot %0d end %0b last %0b",
                     b.kind, b.target_reg, b.target_dat, b.offset, b.slot, b.ended,
                     b.last_beat);
  endfunction

  // compare one output beat with the oldest prediction
  function void check_beat(input logic [OUT_DATA_BITS-1:0] tdata,
                           input logic [KIND_BITS-1:0] tuser, input logic tlast);
    beat_t got;
    beat_t want;
    got.kind       = kind_t'(tuser);
    got.target_reg = tdata[7:0];
    got.target_dat = tdata[15:8];
    got.offset     = tdata[39:16];
    got.slot       = tdata[42:40];
    got.ended      = tdata[43];
    got.last_beat  = tlast;
    if (recorded_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("beat with nothing expected: %s", beat_text(got));
      return;
    end
    want = recorded_beats.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("beat mismatch at %0t", $time);
        $display("  expected %s", beat_text(want));
        $display("  actual   %s", beat_text(got));
      end
    end
  endfunction
endclass

module sound_register_write_translator_tb;

  // cycles with no beat moving on either side before the run is called hung
  localparam int IDLE_LIMIT    = 2000;
  // settle time after the last expected beat
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 357;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_wen   = 1'b0;
  logic [7:0]               cfg_wdata = '0;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata   = '0;   // write_address[15:0], write_data[23:16]
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;          // target_register, target_data,
                                              // stream_offset, loop_slot,
                                              // recording_ended, zero fill
  logic [KIND_BITS-1:0]     m_tuser;          // result_kind
  logic                     m_tlast;          // last_of_item

  srwt_scoreboard board = new();

  int       burst_left  = 0;
  int       idle_cycles = 0;
  int       n_items     = 0;
  int       n_cfg       = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;
  bit       stop_by_end = 1'b0;

  sound_register_write_translator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: runs of always-ready, coin-flip, sparse and solid stall
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= 1'b0;
    endcase
  end

  // monitor: both handshakes are sampled at the edge before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.record_write(s_tdata[15:0], s_tdata[23:16]);
        n_items++;
      end
      if (m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser, m_tlast);
      // watchdog on cycles where neither side moves a beat
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d beats still expected", IDLE_LIMIT,
                 board.recorded_beats.size());
        $display("[sound_register_write_translator] ERROR");
        $finish;
      end
    end
  end

  // one bus write; the sender runs in bursts with random gaps between them
  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender until every predicted beat has come out
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    // wait until the monitor has recorded the last accepted write
    @(posedge clk);
    while (board.recorded_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // command lead byte, written only with the block idle
  task automatic write_lead(input logic [7:0] v);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    board.lead_byte = v;
    n_cfg++;
  endtask

  // random write that never stops recording: mostly sound registers and
  // wave ram, some loop markers, the rest noise anywhere on the bus
  function automatic void pick_write(output logic [15:0] addr, output logic [7:0] data);
    int r;
    int k;
    r    = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    if (r < 45) begin
      addr = {HIGH_PAGE, 8'($urandom_range(16'h10, 16'h26))};
      if (addr[7:0] == MARKER_REG) addr[7:0] = 8'h1A;
    end else if (r < 70) begin
      addr = {HIGH_PAGE, WAVE_WINDOW, 4'($urandom_range(0, 15))};
    end else if (r < 80) begin
      // loop start of any channel or loop end of channels 1 to 3
      k    = $urandom_range(0, 6);
      addr = {HIGH_PAGE, MARKER_REG};
      data = (k < 4) ? 8'h01 << k : 8'h80 | (8'h01 << (k - 3));
    end else if (r < 90) begin
      addr = {HIGH_PAGE, 8'($urandom_range(0, 255))};
      if (addr[7:0] == MARKER_REG) addr[7:0] = 8'h1E;
    end else begin
      addr = 16'($urandom_range(0, 16'hFEFF));
    end
  endfunction

  initial begin
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_lead(8'h00);

    // directed: edges of the page and of the mapped ranges
    send_write(16'h0000, 8'h00);   // bottom of the bus, ignored
    send_write(16'hFEFF, 8'hFF);   // just below the high page
    send_write(16'hFF0F, 8'h5A);   // below the sound registers
    send_write(16'hFF10, 8'hFF);   // first mapped register
    send_write(16'hFF15, 8'h12);   // hole in the register map
    send_write(16'hFF1A, 8'hFF);   // data masked down to bit 7
    send_write(16'hFF1C, 8'hFF);   // data masked down to bits 6:5
    send_write(16'hFF26, 8'h00);   // last mapped register
    send_write(16'hFF27, 8'h33);   // just above the map
    send_write(16'hFF2F, 8'hC3);   // just below wave ram
    send_write(16'hFF30, 8'h00);   // wave ram low edge, two beats
    send_write(16'hFF3F, 8'hFF);   // wave ram high edge
    send_write(16'hFF40, 8'h81);   // just above wave ram
    send_write(16'hFFFF, 8'hAA);   // top of the bus
    // every loop marker that keeps recording going
    send_write(16'hFF1F, 8'h01);
    send_write(16'hFF1F, 8'h02);
    send_write(16'hFF1F, 8'h04);
    send_write(16'hFF1F, 8'h08);
    send_write(16'hFF1F, 8'h82);
    send_write(16'hFF1F, 8'h84);
    send_write(16'hFF1F, 8'h88);
    write_lead(8'hFF);

    // random phases with a new lead byte between them
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick_write(wr_addr, wr_data);
        send_write(wr_addr, wr_data);
      end
      if (p == 1) write_lead(LEAD_RESET);
      else if (p < RANDOM_PHASES - 1) write_lead(8'($urandom_range(1, 254)));
    end

    // stop recording: channel 0 end marker or a marker byte with no slot
    stop_by_end = 1'($urandom_range(0, 1));
    if (stop_by_end) begin
      wr_data = 8'h81;
    end else begin
      do wr_data = 8'($urandom_range(0, 255)); while (loop_slot_for(wr_data) >= 0);
    end
    send_write({HIGH_PAGE, MARKER_REG}, wr_data);
    // once stopped nothing more comes out
    for (int i = 0; i < 8; i++) begin
      pick_write(wr_addr, wr_data);
      send_write(wr_addr, wr_data);
    end
    drain();

    $display("%0d writes: %0d commands, %0d wave ram writes, %0d loop points, %0d lead bytes",
             n_items, board.n_commands, board.n_wave, board.n_loops, n_cfg);
    $display("recording closed by %s at offset %06h, %0d mismatches",
             stop_by_end ? "end marker" : "bad marker", board.byte_count, board.mismatches);
    if (board.mismatches == 0 && board.recorded_beats.size() == 0) begin
      $display("[sound_register_write_translator] OK");
    end else begin
      $display("[sound_register_write_translator] ERROR");
    end
    $finish;
  end

endmodule
